// ===== hw/rtl/stq_pkg.sv =====
// Shared constants and codes for the sorted timeout queue.
`default_nettype none

package stq_pkg;

   localparam int ENTRIES     = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int NRES_W  = $clog2(MAX_RESULTS + 1);

   localparam int FUNC_W   = 2;
   localparam int HANDLE_W = 8;
   localparam int DELAY_W  = 16;
   localparam int TPS_W    = 10;
   localparam int KIND_W   = 3;
   localparam int TICK_W   = 32;
   localparam int PROD_W   = DELAY_W + TPS_W;

   localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(18);

   localparam logic [FUNC_W-1:0] FUNC_SCHEDULE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_CANCEL   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

   localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface stq_req_if;
   import stq_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [HANDLE_W-1:0] handle;
   logic [DELAY_W-1:0]  delay_seconds;

   modport source (output valid, func, handle, delay_seconds, input ready);
   modport sink   (input valid, func, handle, delay_seconds, output ready);
endinterface

interface stq_rsp_if;
   import stq_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [HANDLE_W-1:0] handle_out;
   logic                last;

   modport source (output valid, kind, handle_out, last, input ready);
   modport sink   (input valid, kind, handle_out, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sorted_timeout_queue.sv =====
// Sorted timeout list with tick counter, walked by a shared compare/add unit.
// Steps: a schedule multiplies, adds, searches past 0 to 15 entries and inserts; a full
//   list goes straight to the response; a cancel searches past 0 to 16 entries; a tick
//   advances the counter and removes up to 16 expired entries; a stalled sink holds them back.
// One request at a time: the sequencer walks one entry per cycle (in a tick, held while
//   an expiry waits for the output register) through a single 32-bit comparator and takes
//   the next request in the cycle after the response is loaded.
// Reset (synchronous, active high): empties the list, clears the tick counter and
//   loads ticks_per_second with 18. No clearing pass; list entries stay as they were.
`default_nettype none

module sorted_timeout_queue (
   input  wire                          clock,
   input  wire                          reset,
   stq_req_if.sink                      req_chan,
   stq_rsp_if.source                    rsp_chan,
   input  wire                          csr_we,
   input  wire [stq_pkg::TPS_W-1:0]     csr_wdata
);
   import stq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_SRCH,
      ST_INS,
      ST_CSRCH,
      ST_TICK,
      ST_RESP
   } state_type;

   // Sequencer and request registers
   state_type           state_ff, state_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [DELAY_W-1:0]  delay_ff, delay_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [TICK_W-1:0]   dl_ff, dl_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [NRES_W-1:0]   n_ff, n_in;
   logic                pend_ff, pend_in;
   logic [HANDLE_W-1:0] pend_handle_ff, pend_handle_in;
   logic [KIND_W-1:0]   res_kind_ff, res_kind_in;

   // Architectural state
   logic [TICK_W-1:0]   now_ff, now_in;
   logic [TPS_W-1:0]    tps_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TICK_W-1:0]   dl_arr_ff [ENTRIES];
   logic [HANDLE_W-1:0] hd_arr_ff [ENTRIES];

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic                rsp_last_ff, rsp_last_in;

   // Shared unit operands and list update controls
   logic [TICK_W-1:0]   cmp_a, cmp_b, add_b, add_sum;
   logic                cmp_lt;
   logic [IDX_W-1:0]    pos;
   logic                ins_en, rem_en;
   logic                rsp_free, req_fire, due;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // The output register can take a new beat when empty or being drained now.
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.handle_out = rsp_handle_ff;
   assign rsp_chan.last       = rsp_last_ff;

   // Shared comparator: search walks the new deadline against entry idx;
   // tick checks the head entry against the counter.
   assign pos    = (state_ff == ST_TICK) ? '0 : idx_ff[IDX_W-1:0];
   assign cmp_a  = (state_ff == ST_TICK) ? dl_arr_ff[0] : dl_ff;
   assign cmp_b  = (state_ff == ST_TICK) ? now_ff : dl_arr_ff[pos];
   assign cmp_lt = cmp_a < cmp_b;

   // Shared adder: deadline = now + product, or now + 1 on a tick.
   assign add_b   = (state_ff == ST_ADD) ? TICK_W'(prod_ff) : TICK_W'(1);
   assign add_sum = now_ff + add_b;

   assign due = (count_ff != '0) && cmp_lt && (n_ff < NRES_W'(MAX_RESULTS));

   always_comb begin
      state_in       = state_ff;
      handle_in      = handle_ff;
      delay_in       = delay_ff;
      prod_in        = prod_ff;
      dl_in          = dl_ff;
      idx_in         = idx_ff;
      n_in           = n_ff;
      pend_in        = pend_ff;
      pend_handle_in = pend_handle_ff;
      res_kind_in    = res_kind_ff;
      now_in         = now_ff;
      count_in       = count_ff;
      ins_en         = 1'b0;
      rem_en         = 1'b0;
      // drop the beat the sink takes this cycle
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               handle_in = req_chan.handle;
               delay_in  = req_chan.delay_seconds;
               idx_in    = '0;
               case (req_chan.func)
                  FUNC_SCHEDULE: begin
                     if (count_ff == CNT_W'(ENTRIES)) begin
                        res_kind_in = KIND_FULL;
                        state_in    = ST_RESP;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  FUNC_CANCEL: begin
                     state_in = ST_CSRCH;
                  end
                  FUNC_TICK: begin
                     now_in   = add_sum;
                     n_in     = '0;
                     pend_in  = 1'b0;
                     state_in = ST_TICK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_MUL: begin
            prod_in  = PROD_W'(delay_ff) * PROD_W'(tps_ff);
            state_in = ST_ADD;
         end

         ST_ADD: begin
            dl_in    = add_sum;
            state_in = ST_SRCH;
         end

         ST_SRCH: begin
            // insert before the first entry with a later deadline
            if (idx_ff == count_ff || cmp_lt) begin
               state_in = ST_INS;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_INS: begin
            ins_en      = 1'b1;
            count_in    = count_ff + CNT_W'(1);
            res_kind_in = KIND_SCHEDULED;
            state_in    = ST_RESP;
         end

         ST_CSRCH: begin
            if (idx_ff == count_ff) begin
               res_kind_in = KIND_NOT_FOUND;
               state_in    = ST_RESP;
            end else if (hd_arr_ff[pos] == handle_ff) begin
               rem_en      = 1'b1;
               count_in    = count_ff - CNT_W'(1);
               res_kind_in = KIND_CANCELLED;
               state_in    = ST_RESP;
            end else begin
               idx_in = idx_ff + CNT_W'(1);
            end
         end

         ST_TICK: begin
            // Hold one expired handle back so the final beat can carry last.
            if (due) begin
               if (!pend_ff || rsp_free) begin
                  if (pend_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_EXPIRED;
                     rsp_handle_in = pend_handle_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in        = 1'b1;
                  pend_handle_in = hd_arr_ff[0];
                  rem_en         = 1'b1;
                  count_in       = count_ff - CNT_W'(1);
                  n_in           = n_ff + NRES_W'(1);
               end
            end else if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_EXPIRED;
               rsp_handle_in = pend_handle_ff;
               rsp_last_in   = 1'b1;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = res_kind_ff;
               rsp_handle_in = handle_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         pend_ff      <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         pend_ff      <= pend_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      handle_ff      <= handle_in;
      delay_ff       <= delay_in;
      prod_ff        <= prod_in;
      dl_ff          <= dl_in;
      idx_ff         <= idx_in;
      pend_handle_ff <= pend_handle_in;
      res_kind_ff    <= res_kind_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_last_ff    <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
      end else if (csr_we) begin
         tps_ff <= csr_wdata;
      end
   end

   // List storage: when opening or closing a gap, each shifted entry loads from a fixed neighbor.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (ins_en) begin
            if (IDX_W'(i) == pos) begin
               dl_arr_ff[i] <= dl_ff;
               hd_arr_ff[i] <= handle_ff;
            end else if (i > 0 && IDX_W'(i) > pos) begin
               dl_arr_ff[i] <= dl_arr_ff[(i > 0) ? i - 1 : 0];
               hd_arr_ff[i] <= hd_arr_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (rem_en) begin
            if (i + 1 < ENTRIES && IDX_W'(i) >= pos) begin
               dl_arr_ff[i] <= dl_arr_ff[(i + 1 < ENTRIES) ? i + 1 : i];
               hd_arr_ff[i] <= hd_arr_ff[(i + 1 < ENTRIES) ? i + 1 : i];
            end
         end
      end
   end

   // The list never holds more than its capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above capacity");

   // The list grows or shrinks by at most one entry per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == $past(count_ff)) ||
      (count_ff == $past(count_ff) + CNT_W'(1)) ||
      (count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("entry count jumped");

   // An accepted tick advances the counter by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.func == FUNC_TICK) |=> (now_ff == $past(now_ff) + TICK_W'(1)))
      else $error("tick did not advance counter");

   // No tick expires more than the per-tick limit.
   assert property (@(posedge clock) disable iff (reset)
      n_ff <= NRES_W'(MAX_RESULTS))
      else $error("too many expirations in one tick");

endmodule

`default_nettype wire

// ===== tb/stq_tb_pkg.sv =====
// Timeout-list predictor and expected-response store for the sorted timeout queue bench.
`timescale 1ns / 1ps

package stq_tb_pkg;
   import stq_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [HANDLE_W-1:0] handle;
      logic                last;
   } timeout_event_type;

   class timeout_scoreboard;
      logic [TICK_W-1:0]   deadline_list[ENTRIES];
      logic [HANDLE_W-1:0] handle_list[ENTRIES];
      int unsigned         depth;
      logic [TICK_W-1:0]   tick_count;
      logic [TPS_W-1:0]    rate;
      timeout_event_type   due_events[$];
      int unsigned         failures;

      function new();
         depth      = 0;
         tick_count = '0;
         rate       = TPS_RESET;
         failures   = 0;
      endfunction

      function void set_rate(logic [TPS_W-1:0] value);
         rate = value;
      endfunction

      function int unsigned pending();
         return due_events.size();
      endfunction

      function int unsigned held();
         return depth;
      endfunction

      function logic [HANDLE_W-1:0] held_handle(int unsigned slot);
         return handle_list[slot];
      endfunction

      function void add_event(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                              logic last);
         timeout_event_type ev;
         ev.kind   = kind;
         ev.handle = handle;
         ev.last   = last;
         due_events.push_back(ev);
      endfunction

      // Close the gap at slot and shorten the list.
      function void drop_entry(int unsigned slot);
         for (int unsigned i = slot; i + 1 < depth; i++) begin
            deadline_list[i] = deadline_list[i + 1];
            handle_list[i]   = handle_list[i + 1];
         end
         depth--;
      endfunction

      // Apply one accepted request to the list and queue the responses it causes.
      function void note_request(logic [FUNC_W-1:0] func, logic [HANDLE_W-1:0] handle,
                                 logic [DELAY_W-1:0] delay);
         logic [TICK_W-1:0]   due_at;
         logic [HANDLE_W-1:0] gone;
         int unsigned         slot;
         int unsigned         fired;
         logic                more;
         case (func)
            FUNC_SCHEDULE: begin
               if (depth >= ENTRIES) begin
                  add_event(KIND_FULL, handle, 1'b1);
               end else begin
                  due_at = tick_count + TICK_W'(delay) * TICK_W'(rate);
                  slot = 0;
                  while (slot < depth && !(due_at < deadline_list[slot]))
                     slot++;
                  for (int unsigned i = depth; i > slot; i--) begin
                     deadline_list[i] = deadline_list[i - 1];
                     handle_list[i]   = handle_list[i - 1];
                  end
                  deadline_list[slot] = due_at;
                  handle_list[slot]   = handle;
                  depth++;
                  add_event(KIND_SCHEDULED, handle, 1'b1);
               end
            end
            FUNC_CANCEL: begin
               slot = 0;
               while (slot < depth && handle_list[slot] != handle)
                  slot++;
               if (slot < depth) begin
                  drop_entry(slot);
                  add_event(KIND_CANCELLED, handle, 1'b1);
               end else begin
                  add_event(KIND_NOT_FOUND, handle, 1'b1);
               end
            end
            FUNC_TICK: begin
               tick_count = tick_count + 1;
               fired = 0;
               while (fired < MAX_RESULTS && depth > 0 && deadline_list[0] < tick_count) begin
                  gone = handle_list[0];
                  drop_entry(0);
                  fired++;
                  more = fired < MAX_RESULTS && depth > 0 && deadline_list[0] < tick_count;
                  add_event(KIND_EXPIRED, gone, !more);
               end
            end
            default: ;
         endcase
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(logic [KIND_W-1:0] kind, logic [HANDLE_W-1:0] handle,
                                   logic last);
         timeout_event_type want;
         if (due_events.size() == 0) begin
            $error("unexpected response: kind %0d handle_out 0x%02h last %0d",
                   kind, handle, last);
            failures++;
            return;
         end
         want = due_events.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            failures++;
         end
         if (handle !== want.handle) begin
            $error("handle_out: expected 0x%02h, actual 0x%02h", want.handle, handle);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            failures++;
         end
      endfunction
   endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level bench for the sorted timeout queue: clock, reset, stimulus and response checks.
`timescale 1ns / 1ps

module tb_top;
   import stq_pkg::*;
   import stq_tb_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned PHASE_ITEMS   = 60;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [TPS_W-1:0] csr_wdata;

   stq_req_if req_chan ();
   stq_rsp_if rsp_chan ();

   sorted_timeout_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   timeout_scoreboard board = new();

   bit          req_gaps   = 1'b1;
   bit          rsp_stalls = 1'b1;
   int unsigned cycles     = 0;

   always #10 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check every response beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_response(rsp_chan.kind, rsp_chan.handle_out, rsp_chan.last);
   end

   // Throttle the response side: hold ready low in random bursts,
   // with runs of back-to-back acceptance in between.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stalls && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   // Present one request beat, optionally after a gap, and hold it until accepted.
   // Return at the falling edge after acceptance with valid still high, so that the
   // next call can keep it high without a glitch.
   task automatic send_request(input logic [FUNC_W-1:0]   func,
                               input logic [HANDLE_W-1:0] handle,
                               input logic [DELAY_W-1:0]  delay);
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.func          <= func;
      req_chan.handle        <= handle;
      req_chan.delay_seconds <= delay;
      do @(posedge clock); while (!req_chan.ready);
      board.note_request(func, handle, delay);
      @(negedge clock);
   endtask

   // Drop valid, let every response drain and the sequencer go quiet, then load the rate.
   // Ticks that expire nothing leave no response to wait for, hence the settle time.
   task automatic write_rate(input logic [TPS_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      board.set_rate(value);
   endtask

   // Pick one random request. Weight toward ticks and schedules with short delays so
   // that entries actually come due; aim most cancels at handles still in the list.
   task automatic send_random_item(output bit counted);
      logic [FUNC_W-1:0]   func;
      logic [HANDLE_W-1:0] handle;
      logic [DELAY_W-1:0]  delay;
      int unsigned         pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)
         func = FUNC_SCHEDULE;
      else if (pick < 55)
         func = FUNC_CANCEL;
      else if (pick < 95)
         func = FUNC_TICK;
      else
         func = FUNC_UNUSED;
      handle = HANDLE_W'($urandom_range(0, 255));
      // Reuse a few handles so duplicates sit in the list together.
      if ($urandom_range(0, 3) == 0)
         handle = HANDLE_W'($urandom_range(0, 3));
      if (func == FUNC_CANCEL && board.held() != 0 && $urandom_range(0, 9) < 7)
         handle = board.held_handle($urandom_range(0, board.held() - 1));
      pick = $urandom_range(0, 9);
      if (pick < 7)
         delay = DELAY_W'($urandom_range(0, 3));
      else if (pick < 9)
         delay = DELAY_W'($urandom_range(0, 40));
      else
         delay = DELAY_W'($urandom_range(0, 65535));
      send_request(func, handle, delay);
      counted = (func != FUNC_UNUSED);
   endtask

   // Run one random phase, then cancel whatever is left so far deadlines from a
   // large rate cannot clog the next phase.
   task automatic run_phase(input logic [TPS_W-1:0] value);
      int unsigned sent;
      bit          counted;
      write_rate(value);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         send_random_item(counted);
         if (counted)
            sent++;
      end
      while (board.held() != 0)
         send_request(FUNC_CANCEL, board.held_handle(0), DELAY_W'($urandom_range(0, 65535)));
   endtask

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.func          = FUNC_SCHEDULE;
      req_chan.handle        = '0;
      req_chan.delay_seconds = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, at the reset rate of 18 ticks per second.
      send_request(FUNC_CANCEL, 8'h00, 16'h0000);     // empty list: not found
      send_request(FUNC_TICK, 8'h00, 16'h0000);       // nothing due
      send_request(FUNC_UNUSED, 8'hFF, 16'hFFFF);     // unused code: no response
      send_request(FUNC_SCHEDULE, 8'hFF, 16'h0000);   // due right away
      send_request(FUNC_TICK, 8'h00, 16'h0000);       // single expiry
      send_request(FUNC_SCHEDULE, 8'hA5, 16'h0001);
      send_request(FUNC_CANCEL, 8'hA5, 16'h0000);     // hit
      send_request(FUNC_CANCEL, 8'hA5, 16'h0000);     // already gone
      // Fill the list with equal deadlines; order of arrival must survive.
      for (int i = 0; i < ENTRIES; i++)
         send_request(FUNC_SCHEDULE, HANDLE_W'(i * 17), 16'h0000);
      send_request(FUNC_SCHEDULE, 8'h00, 16'hFFFF);   // full list
      send_request(FUNC_TICK, 8'h00, 16'h0000);       // whole list expires at once
      send_request(FUNC_SCHEDULE, 8'h5A, 16'hFFFF);   // longest delay
      send_request(FUNC_CANCEL, 8'h5A, 16'h0000);

      // Random part across rate settings, extremes included.
      run_phase(TPS_W'(1));
      run_phase(TPS_W'(0));
      run_phase(TPS_W'(1023));
      run_phase(TPS_W'(1000));
      run_phase(TPS_W'($urandom_range(2, 40)));
      // Finish at full rate on both sides.
      req_gaps   = 1'b0;
      rsp_stalls = 1'b0;
      run_phase(TPS_W'($urandom_range(2, 40)));

      req_chan.valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/stq_pkg.sv
hw/rtl/stq_if.sv
hw/rtl/sorted_timeout_queue.sv
tb/stq_tb_pkg.sv
tb/tb_top.sv
